// ===== rtl/core/owm_pkg.sv =====
// owm_pkg: shared constants, types and the quarter-wave sine table for the
// omni wheel mixer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package owm_pkg;

    localparam int SINE_FRAC_BITS = 14;
    localparam int WHEEL_COUNT    = 4;
    localparam int MOVE_POWER     = 100;
    localparam int LIMIT_MAX      = 127;
    localparam int ANGLE_W        = 9;
    localparam int SINE_W         = SINE_FRAC_BITS + 2;   // signed Q1.F
    localparam int MIX_W          = 26;                   // |mix| < 2^24
    localparam int MAG_W          = MIX_W - 1;
    localparam int QUO_W          = 8;                    // quotient up to 127

    localparam logic [1:0] FUNC_MOVE  = 2'd0;
    localparam logic [1:0] FUNC_TURN  = 2'd1;
    localparam logic [1:0] FUNC_BRAKE = 2'd2;
    localparam logic [1:0] FUNC_SPARE = 2'd3;   // no meaning, treated as brake

    localparam logic [1:0] CFG_MOUNT_0 = 2'd0;
    localparam logic [1:0] CFG_MOUNT_1 = 2'd1;
    localparam logic [1:0] CFG_MOUNT_2 = 2'd2;
    localparam logic [1:0] CFG_MOUNT_3 = 2'd3;

    typedef logic [ANGLE_W-1:0] angle_t;
    typedef logic signed [MIX_W-1:0] mix_t;

    // round(sin(k deg) * 65536), k = 0..90
    function automatic logic [16:0] quarter_sine(input logic [6:0] k);
        logic [16:0] t;
        case (k)
            7'd0: t = 17'd0;      7'd1: t = 17'd1144;   7'd2: t = 17'd2287;
            7'd3: t = 17'd3430;   7'd4: t = 17'd4572;   7'd5: t = 17'd5712;
            7'd6: t = 17'd6850;   7'd7: t = 17'd7987;   7'd8: t = 17'd9121;
            7'd9: t = 17'd10252;  7'd10: t = 17'd11380; 7'd11: t = 17'd12505;
            7'd12: t = 17'd13626; 7'd13: t = 17'd14742; 7'd14: t = 17'd15855;
            7'd15: t = 17'd16962; 7'd16: t = 17'd18064; 7'd17: t = 17'd19161;
            7'd18: t = 17'd20252; 7'd19: t = 17'd21336; 7'd20: t = 17'd22415;
            7'd21: t = 17'd23486; 7'd22: t = 17'd24550; 7'd23: t = 17'd25607;
            7'd24: t = 17'd26656; 7'd25: t = 17'd27697; 7'd26: t = 17'd28729;
            7'd27: t = 17'd29753; 7'd28: t = 17'd30767; 7'd29: t = 17'd31772;
            7'd30: t = 17'd32768; 7'd31: t = 17'd33754; 7'd32: t = 17'd34729;
            7'd33: t = 17'd35693; 7'd34: t = 17'd36647; 7'd35: t = 17'd37590;
            7'd36: t = 17'd38521; 7'd37: t = 17'd39441; 7'd38: t = 17'd40348;
            7'd39: t = 17'd41243; 7'd40: t = 17'd42126; 7'd41: t = 17'd42995;
            7'd42: t = 17'd43852; 7'd43: t = 17'd44695; 7'd44: t = 17'd45525;
            7'd45: t = 17'd46341; 7'd46: t = 17'd47143; 7'd47: t = 17'd47930;
            7'd48: t = 17'd48703; 7'd49: t = 17'd49461; 7'd50: t = 17'd50203;
            7'd51: t = 17'd50931; 7'd52: t = 17'd51643; 7'd53: t = 17'd52339;
            7'd54: t = 17'd53020; 7'd55: t = 17'd53684; 7'd56: t = 17'd54332;
            7'd57: t = 17'd54963; 7'd58: t = 17'd55578; 7'd59: t = 17'd56175;
            7'd60: t = 17'd56756; 7'd61: t = 17'd57319; 7'd62: t = 17'd57865;
            7'd63: t = 17'd58393; 7'd64: t = 17'd58903; 7'd65: t = 17'd59396;
            7'd66: t = 17'd59870; 7'd67: t = 17'd60326; 7'd68: t = 17'd60764;
            7'd69: t = 17'd61183; 7'd70: t = 17'd61584; 7'd71: t = 17'd61965;
            7'd72: t = 17'd62328; 7'd73: t = 17'd62672; 7'd74: t = 17'd62997;
            7'd75: t = 17'd63303; 7'd76: t = 17'd63589; 7'd77: t = 17'd63856;
            7'd78: t = 17'd64104; 7'd79: t = 17'd64332; 7'd80: t = 17'd64540;
            7'd81: t = 17'd64729; 7'd82: t = 17'd64898; 7'd83: t = 17'd65048;
            7'd84: t = 17'd65177; 7'd85: t = 17'd65287; 7'd86: t = 17'd65376;
            7'd87: t = 17'd65446; 7'd88: t = 17'd65496; 7'd89: t = 17'd65526;
            7'd90: t = 17'd65536;
            default: t = 17'd0;
        endcase
        return t;
    endfunction

    // Quarter-wave entry rounded half up to Q(SINE_FRAC_BITS)
    function automatic logic [SINE_W-1:0] table_q(input logic [6:0] k);
        logic [16+SINE_FRAC_BITS:0] w;
        w = ({{SINE_FRAC_BITS{1'b0}}, quarter_sine(k)} << SINE_FRAC_BITS)
            + (17+SINE_FRAC_BITS)'(32768);
        return SINE_W'(w >> 16);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/omni_wheel_mixer_core.sv =====
// omni_wheel_mixer_core: top level of the four-wheel omni drive mixer.
// Depends on owm_pkg for constants and the sine table.
//
// Usage:
//   s_axis_* carries one command per transfer; m_axis_* returns one result
//   per command. cfg_* writes mount angles (index 0..3, others ignored) and
//   is always ready; write it only while the pipeline is empty.
// Timing:
//   Fifteen register stages: input, angle, sine, mix, max magnitude, scale
//   by L, then eight restoring-division stages (one quotient bit each), and
//   clamp into the output register. One command is taken every cycle while
//   the output stage is not held full by a low m_axis_tready.
// Reset:
//   rst_n clears every stage's valid bit and loads the default mount angles
//   45, 135, 225, 315.
// Stall:
//   When the output stage is full and m_axis_tready is low, the whole
//   pipeline holds; s_axis_tready drops only when the output stage is full
//   and not drained, so no item is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module omni_wheel_mixer_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] func, [10:2] heading_deg, [18:11] power_limit, [27:19] turn_power
    input  wire  [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [7:0] wheel_0, [15:8] wheel_1, [23:16] wheel_2, [31:24] wheel_3
    output logic [31:0] m_axis_tdata,
    // [0] brake
    output logic        m_axis_tuser,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [8:0]  cfg_data
);
    localparam int NS  = 15;               // stages 0..14
    localparam int W   = owm_pkg::WHEEL_COUNT;
    localparam int MW  = owm_pkg::MIX_W;
    localparam int GW  = owm_pkg::MAG_W;
    localparam int PW  = GW + 7;           // |mix| * L
    localparam int DS  = 5;                // product stage; the divide stages follow it
    localparam int QW  = owm_pkg::QUO_W;

    logic [NS-1:0] vld_reg;
    logic          adv;
    assign adv = !vld_reg[NS-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = vld_reg[NS-1];

    owm_pkg::angle_t mount_reg [W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mount_reg[0] <= 9'd45;
            mount_reg[1] <= 9'd135;
            mount_reg[2] <= 9'd225;
            mount_reg[3] <= 9'd315;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                owm_pkg::CFG_MOUNT_0: mount_reg[0] <= cfg_data;
                owm_pkg::CFG_MOUNT_1: mount_reg[1] <= cfg_data;
                owm_pkg::CFG_MOUNT_2: mount_reg[2] <= cfg_data;
                owm_pkg::CFG_MOUNT_3: mount_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NS-2:0], s_axis_tvalid};
    end

    // Per-item side info carried down the pipe: mode, limit, turn power
    logic [1:0]        func_reg  [NS];
    logic [6:0]        lim_reg   [NS];
    logic signed [8:0] turn_reg  [NS];

    // Stage 0: input decode
    logic [1:0]        in_func;
    logic [8:0]        in_head;
    logic signed [7:0] in_lim;
    logic [7:0]        in_abs;
    assign in_func = s_axis_tdata[1:0];
    assign in_head = s_axis_tdata[10:2];
    assign in_lim  = s_axis_tdata[18:11];
    assign in_abs  = in_lim[7] ? 8'(-in_lim) : 8'(in_lim);

    // Stage 0 -> 1 angle: (1350 - heading - mount) mod 360
    logic [8:0]  head_reg;
    logic [8:0]  ang_reg [W];
    logic [11:0] araw    [W];
    logic [8:0]  ang_next[W];

    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            araw[i] = 12'd1350 - {3'd0, head_reg} - {3'd0, mount_reg[i]};
            // value 328..1350: at most three subtractions of 360
            if (araw[i] >= 12'd1080)     ang_next[i] = 9'(araw[i] - 12'd1080);
            else if (araw[i] >= 12'd720) ang_next[i] = 9'(araw[i] - 12'd720);
            else if (araw[i] >= 12'd360) ang_next[i] = 9'(araw[i] - 12'd360);
            else                         ang_next[i] = 9'(araw[i]);
        end
    end

    // Stage 2 sine, signed
    logic signed [owm_pkg::SINE_W-1:0] sin_reg [W];
    logic signed [owm_pkg::SINE_W-1:0] sin_next[W];
    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            if (ang_reg[i] <= 9'd90)
                sin_next[i] = owm_pkg::table_q(7'(ang_reg[i]));
            else if (ang_reg[i] <= 9'd180)
                sin_next[i] = owm_pkg::table_q(7'(9'd180 - ang_reg[i]));
            else if (ang_reg[i] <= 9'd270)
                sin_next[i] = -owm_pkg::table_q(7'(ang_reg[i] - 9'd180));
            else
                sin_next[i] = -owm_pkg::table_q(7'(9'd360 - ang_reg[i]));
        end
    end

    // Stage 3 mix = +-sin*100 + turn<<F
    owm_pkg::mix_t mix_reg [W];
    owm_pkg::mix_t mix_next[W];
    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            mix_next[i] = MW'(sin_reg[i]) * MW'(owm_pkg::MOVE_POWER);
            if (i == 1 || i == 2)
                mix_next[i] = -mix_next[i];
            mix_next[i] = mix_next[i]
                + (MW'(turn_reg[2]) <<< owm_pkg::SINE_FRAC_BITS);
        end
    end

    // Stage 4 magnitudes and max
    logic [GW-1:0] mag_reg [W];
    logic          neg_reg [NS][W];
    logic [GW-1:0] mag_next[W];
    logic [GW-1:0] max_reg;
    logic [GW-1:0] max_next;
    always_comb
    begin
        max_next = '0;
        for (int i = 0; i < W; i++)
        begin
            mag_next[i] = mix_reg[i][MW-1] ? GW'(-mix_reg[i]) : GW'(mix_reg[i]);
            if (mag_next[i] > max_next)
                max_next = mag_next[i];
        end
    end

    // Stage 5 product |mix|*L, then 8 restoring division steps
    logic [PW-1:0] rem_reg [NS][W];
    logic [QW-1:0] quo_reg [NS][W];
    logic [GW-1:0] div_reg [NS];
    logic [PW-1:0] rem_next[NS][W];
    logic [QW-1:0] quo_next[NS][W];
    logic [PW+QW-1:0] trial[NS][W];

    always_comb
    begin
        for (int s = 0; s < NS; s++)
            for (int i = 0; i < W; i++)
            begin
                rem_next[s][i] = rem_reg[s][i];
                quo_next[s][i] = quo_reg[s][i];
                trial[s][i] = '0;
            end
        for (int i = 0; i < W; i++)
        begin
            rem_next[DS][i] = PW'(mag_reg[i]) * PW'(lim_reg[4]);
            quo_next[DS][i] = '0;
        end
        // stage DS+1+k produces quotient bit QW-1-k
        for (int k = 0; k < QW; k++)
            for (int i = 0; i < W; i++)
            begin
                trial[DS+1+k][i] = (PW+QW)'(div_reg[DS+k]) << (QW-1-k);
                if ((PW+QW)'(rem_reg[DS+k][i]) >= trial[DS+1+k][i])
                begin
                    rem_next[DS+1+k][i] = PW'((PW+QW)'(rem_reg[DS+k][i])
                                             - trial[DS+1+k][i]);
                    quo_next[DS+1+k][i] = quo_reg[DS+k][i] | (QW'(1) << (QW-1-k));
                end
                else
                begin
                    rem_next[DS+1+k][i] = rem_reg[DS+k][i];
                    quo_next[DS+1+k][i] = quo_reg[DS+k][i];
                end
            end
    end

    // Stage 13 -> 14: select mode, clamp, sign
    logic [7:0] res_next[W];
    logic [7:0] res_reg [W];
    logic       brk_reg;
    logic [7:0] q;
    logic signed [8:0] l9;
    logic signed [8:0] t9;
    always_comb
    begin
        l9 = {2'b00, lim_reg[NS-2]};
        t9 = turn_reg[NS-2];
        for (int i = 0; i < W; i++)
        begin
            q = (quo_reg[NS-2][i] > 8'(lim_reg[NS-2])) ?
                8'(lim_reg[NS-2]) : quo_reg[NS-2][i];
            res_next[i] = 8'd0;
            if (func_reg[NS-2] == owm_pkg::FUNC_MOVE)
            begin
                if (div_reg[NS-2] != '0)
                    res_next[i] = neg_reg[NS-2][i] ? 8'(-q) : q;
            end
            else if (func_reg[NS-2] == owm_pkg::FUNC_TURN)
            begin
                if (t9 > l9)       res_next[i] = 8'(l9);
                else if (t9 < -l9) res_next[i] = 8'(-l9);
                else               res_next[i] = 8'(t9);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            func_reg[0] <= in_func;
            lim_reg[0]  <= (in_abs > 8'd127) ? 7'd127 : 7'(in_abs);
            turn_reg[0] <= s_axis_tdata[27:19];
            head_reg    <= in_head;
            for (int s = 1; s < NS; s++)
            begin
                func_reg[s] <= func_reg[s-1];
                lim_reg[s]  <= lim_reg[s-1];
                turn_reg[s] <= turn_reg[s-1];
                // load the divisor at the product stage, else advance
                div_reg[s]  <= (s == DS) ? max_reg : div_reg[s-1];
                // sign enters beside the magnitudes, then advances
                for (int i = 0; i < W; i++)
                    neg_reg[s][i] <= (s == DS - 1) ? mix_reg[i][MW-1]
                                                   : neg_reg[s-1][i];
            end
            div_reg[0] <= '0;
            for (int i = 0; i < W; i++)
            begin
                neg_reg[0][i] <= 1'b0;
                ang_reg[i] <= ang_next[i];
                sin_reg[i] <= sin_next[i];
                mix_reg[i] <= mix_next[i];
                mag_reg[i] <= mag_next[i];
                res_reg[i] <= res_next[i];
                for (int s = 0; s < NS; s++)
                begin
                    rem_reg[s][i] <= rem_next[s][i];
                    quo_reg[s][i] <= quo_next[s][i];
                end
            end
            max_reg <= max_next;
            brk_reg <= (func_reg[NS-2] == owm_pkg::FUNC_BRAKE) ||
                       (func_reg[NS-2] == owm_pkg::FUNC_SPARE);
        end
    end

    assign m_axis_tdata = {res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
    assign m_axis_tuser = brk_reg;

endmodule
`default_nettype wire

// ===== dv/omni_wheel_mixer_core_test.sv =====
// omni_wheel_mixer_core_test: self-checking testbench for the omni wheel mixer core.
// Depends on owm_pkg and omni_wheel_mixer_core; predicts each wheel result in place.
`timescale 1ns / 1ps
module omni_wheel_mixer_core_test;

    typedef struct packed {
        logic [7:0] w3;
        logic [7:0] w2;
        logic [7:0] w1;
        logic [7:0] w0;
        logic       brake;
    } wheel_result_t;

    localparam int LATENCY = 15;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_data;

    // Shadow copy of the mount angle registers
    logic [8:0] mount_deg [4];

    wheel_result_t expected_wheels[$];
    int mismatch_count;
    int results_seen;
    // Receiver hold-off requested by a test, in cycles
    int hold_cycles;
    bit random_stall;

    omni_wheel_mixer_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Sine of a whole degree in Q(SINE_FRAC_BITS), from the quarter wave
    function automatic longint sine_q(input int d);
        int     k;
        longint t;
        longint s;
        if (d <= 90)
            k = d;
        else if (d <= 180)
            k = 180 - d;
        else if (d <= 270)
            k = d - 180;
        else
            k = 360 - d;
        case (k)
            0: t = 0; 1: t = 1144; 2: t = 2287; 3: t = 3430; 4: t = 4572;
            5: t = 5712; 6: t = 6850; 7: t = 7987; 8: t = 9121; 9: t = 10252;
            10: t = 11380; 11: t = 12505; 12: t = 13626; 13: t = 14742;
            14: t = 15855; 15: t = 16962; 16: t = 18064; 17: t = 19161;
            18: t = 20252; 19: t = 21336; 20: t = 22415; 21: t = 23486;
            22: t = 24550; 23: t = 25607; 24: t = 26656; 25: t = 27697;
            26: t = 28729; 27: t = 29753; 28: t = 30767; 29: t = 31772;
            30: t = 32768; 31: t = 33754; 32: t = 34729; 33: t = 35693;
            34: t = 36647; 35: t = 37590; 36: t = 38521; 37: t = 39441;
            38: t = 40348; 39: t = 41243; 40: t = 42126; 41: t = 42995;
            42: t = 43852; 43: t = 44695; 44: t = 45525; 45: t = 46341;
            46: t = 47143; 47: t = 47930; 48: t = 48703; 49: t = 49461;
            50: t = 50203; 51: t = 50931; 52: t = 51643; 53: t = 52339;
            54: t = 53020; 55: t = 53684; 56: t = 54332; 57: t = 54963;
            58: t = 55578; 59: t = 56175; 60: t = 56756; 61: t = 57319;
            62: t = 57865; 63: t = 58393; 64: t = 58903; 65: t = 59396;
            66: t = 59870; 67: t = 60326; 68: t = 60764; 69: t = 61183;
            70: t = 61584; 71: t = 61965; 72: t = 62328; 73: t = 62672;
            74: t = 62997; 75: t = 63303; 76: t = 63589; 77: t = 63856;
            78: t = 64104; 79: t = 64332; 80: t = 64540; 81: t = 64729;
            82: t = 64898; 83: t = 65048; 84: t = 65177; 85: t = 65287;
            86: t = 65376; 87: t = 65446; 88: t = 65496; 89: t = 65526;
            default: t = 65536;
        endcase
        // round half up from Q16
        s = ((t << owm_pkg::SINE_FRAC_BITS) + 32768) >>> 16;
        return (d > 180) ? -s : s;
    endfunction

    function automatic wheel_result_t mix_wheels(input logic [1:0] func,
                                                 input logic [8:0] heading,
                                                 input logic signed [7:0] limit,
                                                 input logic signed [8:0] turn);
        wheel_result_t r;
        longint lim;
        longint mix [4];
        longint wheel [4];
        longint maxmag;
        longint mag;
        longint q;
        int     ang;
        r = '0;
        lim = (limit < 0) ? -longint'(limit) : longint'(limit);
        if (lim > owm_pkg::LIMIT_MAX)
            lim = owm_pkg::LIMIT_MAX;
        maxmag = 0;
        for (int i = 0; i < 4; i++)
            wheel[i] = 0;
        if (func == owm_pkg::FUNC_MOVE)
        begin
            for (int i = 0; i < 4; i++)
            begin
                ang = (1350 - int'(heading) - int'(mount_deg[i])) % 360;
                mix[i] = sine_q(ang) * owm_pkg::MOVE_POWER
                         * ((i == 1 || i == 2) ? -1 : 1)
                         + longint'(turn) * (longint'(1) << owm_pkg::SINE_FRAC_BITS);
                mag = (mix[i] < 0) ? -mix[i] : mix[i];
                if (mag > maxmag)
                    maxmag = mag;
            end
            if (maxmag != 0)
                for (int i = 0; i < 4; i++)
                begin
                    q = (mix[i] * lim) / maxmag;
                    wheel[i] = (q > lim) ? lim : ((q < -lim) ? -lim : q);
                end
        end
        else if (func == owm_pkg::FUNC_TURN)
        begin
            for (int i = 0; i < 4; i++)
                wheel[i] = (turn > lim) ? lim : ((turn < -lim) ? -lim : longint'(turn));
        end
        else
            r.brake = 1'b1;
        r.w0 = wheel[0][7:0];
        r.w1 = wheel[1][7:0];
        r.w2 = wheel[2][7:0];
        r.w3 = wheel[3][7:0];
        return r;
    endfunction

    // Offer one command after a random gap, record its prediction on transfer;
    // tvalid stays high after the transfer so commands can follow back to back
    task automatic send_command(input logic [1:0] func, input logic [8:0] heading,
                                input logic [7:0] limit, input logic [8:0] turn,
                                input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, turn, limit, heading, func};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_wheels.push_back(mix_wheels(func, heading, limit, turn));
    endtask

    // Drop tvalid, wait until every prediction is compared, then let the pipeline settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_wheels.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 3)
            @(posedge clk);
    endtask

    task automatic write_mount(input logic [1:0] idx, input logic [8:0] deg);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= deg;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        mount_deg[idx] = deg;
        @(posedge clk);
    endtask

    task automatic send_random(input int count);
        logic [1:0] f;
        for (int n = 0; n < count; n++)
        begin
            f = ($urandom_range(0, 9) < 6) ? owm_pkg::FUNC_MOVE
                                           : 2'($urandom_range(1, 3));
            send_command(f, 9'($urandom_range(0, 359)), 8'($urandom),
                         9'($urandom_range(0, 510) - 255));
        end
    endtask

    // Extremes of every field, every function code and the special cases
    task automatic test_directed();
        send_command(owm_pkg::FUNC_MOVE, 9'd0, 8'd127, 9'd0);
        send_command(owm_pkg::FUNC_MOVE, 9'd359, 8'h81, 9'd255);
        send_command(owm_pkg::FUNC_MOVE, 9'd90, 8'h80, -9'sd255);
        send_command(owm_pkg::FUNC_MOVE, 9'd45, 8'd0, 9'd100);
        send_command(owm_pkg::FUNC_MOVE, 9'd180, 8'd1, -9'sd1);
        send_command(owm_pkg::FUNC_MOVE, 9'd270, 8'hff, 9'h100);
        send_command(owm_pkg::FUNC_MOVE, 9'd511, 8'd100, 9'd0);
        send_command(owm_pkg::FUNC_TURN, 9'd0, 8'd50, 9'd255);
        send_command(owm_pkg::FUNC_TURN, 9'd0, 8'h80, -9'sd255);
        send_command(owm_pkg::FUNC_TURN, 9'd0, 8'h9c, 9'd20);
        send_command(owm_pkg::FUNC_TURN, 9'd300, 8'd0, 9'h100);
        send_command(owm_pkg::FUNC_BRAKE, 9'h1ff, 8'hff, 9'h1ff);
        send_command(owm_pkg::FUNC_SPARE, 9'd10, 8'd60, 9'd10);
        drain_results();
        // Zero mix: mounts chosen so every sine term is zero with no turn
        write_mount(owm_pkg::CFG_MOUNT_0, 9'd90);
        write_mount(owm_pkg::CFG_MOUNT_1, 9'd270);
        write_mount(owm_pkg::CFG_MOUNT_2, 9'd90);
        write_mount(owm_pkg::CFG_MOUNT_3, 9'd270);
        send_command(owm_pkg::FUNC_MOVE, 9'd0, 8'd127, 9'd0);
        send_command(owm_pkg::FUNC_MOVE, 9'd180, 8'h81, 9'd0);
        send_command(owm_pkg::FUNC_MOVE, 9'd0, 8'd127, 9'd7);
        drain_results();
    endtask

    // Random commands over several mount settings, extremes included
    task automatic test_mount_settings();
        for (int p = 0; p < 6; p++)
        begin
            for (int i = 0; i < 4; i++)
                write_mount(2'(i), (p == 0) ? 9'd0 : (p == 1) ? 9'd359 :
                            (p == 2) ? 9'h1ff : 9'($urandom));
            send_random(90);
            drain_results();
        end
    endtask

    // Stall the receiver long while the sender keeps offering
    task automatic test_backpressure();
        hold_cycles = 60;
        for (int n = 0; n < 40; n++)
            send_command(owm_pkg::FUNC_MOVE, 9'($urandom_range(0, 359)), 8'($urandom),
                         9'($urandom), 1);
        drain_results();
    endtask

    // Default mounts again, a back-to-back burst with no gaps or receiver stalls, then random traffic
    task automatic test_default_random();
        write_mount(owm_pkg::CFG_MOUNT_0, 9'd45);
        write_mount(owm_pkg::CFG_MOUNT_1, 9'd135);
        write_mount(owm_pkg::CFG_MOUNT_2, 9'd225);
        write_mount(owm_pkg::CFG_MOUNT_3, 9'd315);
        random_stall = 1'b0;
        for (int n = 0; n < 60; n++)
            send_command(2'($urandom), 9'($urandom), 8'($urandom), 9'($urandom), 1);
        random_stall = 1'b1;
        send_random(270);
        drain_results();
    endtask

    // Receiver: random stalls per result, plus long hold-offs on request
    initial
    begin
        int wait_n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles)
                    @(posedge clk);
                hold_cycles = 0;
            end
            wait_n = random_stall ? $urandom_range(0, 13) : 0;
            if ($urandom_range(0, 2) == 0)
                wait_n = 0;
            if (wait_n > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (wait_n)
                    @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // Checker: compare each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        wheel_result_t got;
        wheel_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata, m_axis_tuser};
            results_seen++;
            if (expected_wheels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_wheels.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result %0d mismatch: expected w %0d %0d %0d %0d b %0b,",
                                  " got w %0d %0d %0d %0d b %0b"},
                                 results_seen, $signed(want.w0), $signed(want.w1),
                                 $signed(want.w2), $signed(want.w3), want.brake,
                                 $signed(got.w0), $signed(got.w1), $signed(got.w2),
                                 $signed(got.w3), got.brake);
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("omni_wheel_mixer_core_test failed");
        $finish;
    end

    initial
    begin
        mismatch_count = 0;
        results_seen   = 0;
        hold_cycles    = 0;
        random_stall   = 1'b1;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        mount_deg[0] = 9'd45;
        mount_deg[1] = 9'd135;
        mount_deg[2] = 9'd225;
        mount_deg[3] = 9'd315;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_mount_settings();
        test_backpressure();
        test_default_random();
        if (mismatch_count == 0 && expected_wheels.size() == 0)
            $display("omni_wheel_mixer_core_test passed");
        else
            $display("omni_wheel_mixer_core_test failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/owm_pkg.sv
rtl/core/omni_wheel_mixer_core.sv
dv/omni_wheel_mixer_core_test.sv
